/* sv/sidt_pkg.sv */
`default_nettype none

package sidt_pkg;

    localparam int CMD_W      = 2;
    localparam int SVC_IN_W   = 4;
    localparam int WORKER_W   = 7;
    localparam int HASH_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_O_W  = 4;

    // hash modulo: bits retired per cycle
    localparam int MOD_BITS   = 8;
    localparam int MOD_STEPS  = HASH_W / MOD_BITS;
    localparam int MOD_STEP_W = $clog2(MOD_STEPS);

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] RD_IDX      = 2'd0;
    localparam logic [1:0] RD_IDX_NEXT = 2'd1;
    localparam logic [1:0] RD_REM      = 2'd2;

    typedef struct packed {
        logic                capture;
        logic                rd_en;
        logic [1:0]          rd_src;
        logic                wr_add;
        logic                wr_shift;
        logic                idx_inc;
        logic                mod_step;
        logic                dec_count;
        logic                load_out;
        logic [STATUS_W-1:0] out_status;
        logic                out_pick;
    } sidt_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             svc_ok;
        logic             cnt_zero;
        logic             cnt_full;
        logic             idx_last;
        logic             match;
        logic             mod_last;
        logic             out_free;
    } sidt_stat_t;

endpackage

`default_nettype wire

/* sv/sidt_ctrl.sv */
`default_nettype none

module sidt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire sidt_pkg::sidt_stat_t stat,
    output sidt_pkg::sidt_ctrl_t    ctl
);
    import sidt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_MOD      = 4'd2;
    localparam logic [3:0] S_LREAD    = 4'd3;
    localparam logic [3:0] S_SRCH_RD  = 4'd4;
    localparam logic [3:0] S_SRCH_CHK = 4'd5;
    localparam logic [3:0] S_SHF_RD   = 4'd6;
    localparam logic [3:0] S_SHF_WR   = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                pick_reg, pick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            pick_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            pick_reg       <= pick_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl             = '0;
        ctl.out_status  = res_status_reg;
        ctl.out_pick    = pick_reg;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        pick_next       = pick_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                pick_next       = 1'b0;
                res_status_next = ST_OK;
                state_next      = S_OUT;
                if (!stat.svc_ok)
                begin
                    case (stat.op)
                        CMD_LOOKUP: res_status_next = ST_EMPTY;
                        CMD_ADD:    res_status_next = ST_FULL;
                        CMD_REMOVE: res_status_next = ST_NOT_FOUND;
                        default:    res_status_next = ST_OK;
                    endcase
                end
                else
                begin
                    case (stat.op)
                        CMD_LOOKUP:
                        begin
                            if (stat.cnt_zero)
                                res_status_next = ST_EMPTY;
                            else
                                state_next = S_MOD;
                        end
                        CMD_ADD:
                        begin
                            if (stat.cnt_full)
                                res_status_next = ST_FULL;
                            else
                                ctl.wr_add = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            if (stat.cnt_zero)
                                res_status_next = ST_NOT_FOUND;
                            else
                                state_next = S_SRCH_RD;
                        end
                        default: res_status_next = ST_OK;
                    endcase
                end
            end
            S_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (stat.mod_last)
                    state_next = S_LREAD;
            end
            S_LREAD:
            begin
                ctl.rd_en       = 1'b1;
                ctl.rd_src      = RD_REM;
                res_status_next = ST_OK;
                pick_next       = 1'b1;
                state_next      = S_OUT;
            end
            S_SRCH_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = RD_IDX;
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (stat.match)
                    state_next = S_SHF_RD;
                else if (stat.idx_last)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_OUT;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SHF_RD:
            begin
                if (stat.idx_last)
                begin
                    ctl.dec_count   = 1'b1;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_src = RD_IDX_NEXT;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR:
            begin
                ctl.wr_shift = 1'b1;
                ctl.idx_inc  = 1'b1;
                state_next   = S_SHF_RD;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> stat.out_free)
        else $error("result loaded over a pending one");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_add && ctl.wr_shift))
        else $error("two list writes in one cycle");
`endif

endmodule

`default_nettype wire

/* sv/sidt_dp.sv */
`default_nettype none

module sidt_dp #(
    parameter int NUM_SERVICES = 16,
    parameter int LIST_DEPTH   = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [sidt_pkg::CMD_W-1:0]     cmd,
    input  wire logic [sidt_pkg::SVC_IN_W-1:0]  service,
    input  wire logic [sidt_pkg::WORKER_W-1:0]  worker_id,
    input  wire logic [sidt_pkg::HASH_W-1:0]    flow_hash,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output logic [sidt_pkg::WORKER_W-1:0]       chosen_worker,
    output logic [sidt_pkg::STATUS_W-1:0]       status,
    output logic [sidt_pkg::COUNT_O_W-1:0]      list_count,
    input  wire sidt_pkg::sidt_ctrl_t           ctl,
    output sidt_pkg::sidt_stat_t                stat
);
    import sidt_pkg::*;

    localparam int MEM_DEPTH = NUM_SERVICES * LIST_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SVC_W     = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int IW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [CMD_W-1:0]      op_reg;
    logic                  svc_ok_reg;
    logic [SVC_W-1:0]      svc_reg;
    logic [WORKER_W-1:0]   wid_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [IW-1:0]         idx_reg;
    logic [CW-1:0]         rem_reg;
    logic [CW-1:0]         rem_next;
    logic [MOD_STEP_W-1:0] mod_cnt_reg;
    logic [CW-1:0]         counts_reg [NUM_SERVICES];
    logic [WORKER_W-1:0]   mem [MEM_DEPTH];
    logic [WORKER_W-1:0]   rd_data_reg;

    logic                  rsp_valid_reg;
    logic [WORKER_W-1:0]   rsp_worker_reg;
    logic [STATUS_W-1:0]   rsp_status_reg;
    logic [COUNT_O_W-1:0]  rsp_count_reg;

    logic                  svc_in_ok;
    logic [SVC_W-1:0]      svc_in;
    logic                  count_we;
    logic [CW-1:0]         rd_off;
    logic [CW-1:0]         wr_off;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;
    logic [WORKER_W-1:0]   wr_data;
    logic [CW:0]           mod_t;
    logic [CW-1:0]         mod_r;

    assign svc_in_ok = (32'(service) < 32'(NUM_SERVICES));
    assign svc_in    = SVC_W'(service);
    assign count_we  = ctl.wr_add | ctl.dec_count;
    assign cnt_next  = ctl.wr_add ? (cnt_reg + CW'(1)) : (cnt_reg - CW'(1));

    // capture and working registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg     <= cmd;
            svc_ok_reg <= svc_in_ok;
            svc_reg    <= svc_in;
            wid_reg    <= worker_id;
            hash_reg   <= flow_hash;
            cnt_reg    <= svc_in_ok ? counts_reg[svc_in] : '0;
            idx_reg    <= '0;
            rem_reg    <= '0;
        end
        else
        begin
            if (count_we)
                cnt_reg <= cnt_next;
            if (ctl.idx_inc)
                idx_reg <= idx_reg + IW'(1);
            if (ctl.mod_step)
            begin
                rem_reg  <= rem_next;
                hash_reg <= hash_reg << MOD_BITS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_cnt_reg <= '0;
        else if (ctl.capture)
            mod_cnt_reg <= '0;
        else if (ctl.mod_step)
            mod_cnt_reg <= mod_cnt_reg + MOD_STEP_W'(1);
    end

    // restoring remainder, MOD_BITS hash bits a cycle
    always_comb
    begin
        mod_r = rem_reg;
        mod_t = '0;
        for (int k = 0; k < MOD_BITS; k++)
        begin
            mod_t = {mod_r, hash_reg[HASH_W-1-k]};
            if (mod_t >= {1'b0, cnt_reg})
                mod_t = mod_t - {1'b0, cnt_reg};
            mod_r = mod_t[CW-1:0];
        end
        rem_next = mod_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SERVICES; s++)
                counts_reg[s] <= '0;
        end
        else if (count_we)
            counts_reg[svc_reg] <= cnt_next;
    end

    // instance list memory
    always_comb
    begin
        case (ctl.rd_src)
            RD_IDX:      rd_off = CW'(idx_reg);
            RD_IDX_NEXT: rd_off = CW'(idx_reg) + CW'(1);
            RD_REM:      rd_off = rem_reg;
            default:     rd_off = CW'(idx_reg);
        endcase
    end

    assign wr_off  = ctl.wr_add ? cnt_reg : CW'(idx_reg);
    assign rd_addr = AW'(32'(svc_reg) * LIST_DEPTH + 32'(rd_off));
    assign wr_addr = AW'(32'(svc_reg) * LIST_DEPTH + 32'(wr_off));
    assign wr_en   = ctl.wr_add | ctl.wr_shift;
    assign wr_data = ctl.wr_add ? wid_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctl.load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            rsp_worker_reg <= ctl.out_pick ? rd_data_reg : '0;
            rsp_status_reg <= ctl.out_status;
            rsp_count_reg  <= COUNT_O_W'(cnt_reg);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign chosen_worker = rsp_worker_reg;
    assign status        = rsp_status_reg;
    assign list_count    = rsp_count_reg;

    assign stat.op       = op_reg;
    assign stat.svc_ok   = svc_ok_reg;
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.cnt_full = (cnt_reg == CW'(LIST_DEPTH));
    assign stat.idx_last = ((CW'(idx_reg) + CW'(1)) >= cnt_reg);
    assign stat.match    = (rd_data_reg == wid_reg);
    assign stat.mod_last = (mod_cnt_reg == MOD_STEP_W'(MOD_STEPS - 1));
    assign stat.out_free = !rsp_valid_reg || rsp_ready;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_we |-> (cnt_next <= CW'(LIST_DEPTH)))
        else $error("instance count beyond list depth");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < MEM_DEPTH))
        else $error("list write outside memory");

    a_fail_no_worker: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg != ST_OK)) |-> (rsp_worker_reg == '0))
        else $error("worker given with a failing status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg == ST_EMPTY)) |-> (rsp_count_reg == '0))
        else $error("empty status with non-zero count");
`endif

endmodule

`default_nettype wire

/* sv/service_instance_dispatch_table.sv */
`default_nettype none

// Per-service worker dispatch table. Each of NUM_SERVICES services holds a
// packed list of up to LIST_DEPTH worker IDs and a count. cmd selects lookup
// (entry at flow_hash mod count), add (append) or remove (first match taken
// out, later entries shifted down). One item is worked on at a time and each
// gives exactly one result on the rsp channel. Add and unused commands go
// straight to the result. Lookup retires 8 hash bits a cycle into the
// remainder, then does one list read. Remove searches by reading and then
// comparing each entry in turn, and the shift reads and writes each later
// entry. A new item is accepted only once the last result is loaded, so a
// previous result still waiting on rsp_ready delays the next acceptance.
// Counts reset to zero; list entries need no clearing.
module service_instance_dispatch_table #(
    parameter int NUM_SERVICES = 16,
    parameter int LIST_DEPTH   = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire logic [sidt_pkg::CMD_W-1:0]     cmd,
    input  wire logic [sidt_pkg::SVC_IN_W-1:0]  service,
    input  wire logic [sidt_pkg::WORKER_W-1:0]  worker_id,
    input  wire logic [sidt_pkg::HASH_W-1:0]    flow_hash,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output logic [sidt_pkg::WORKER_W-1:0]       chosen_worker,
    output logic [sidt_pkg::STATUS_W-1:0]       status,
    output logic [sidt_pkg::COUNT_O_W-1:0]      list_count
);
    import sidt_pkg::*;

    sidt_ctrl_t ctl;
    sidt_stat_t stat;

    sidt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    sidt_dp #(
        .NUM_SERVICES (NUM_SERVICES),
        .LIST_DEPTH   (LIST_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .service       (service),
        .worker_id     (worker_id),
        .flow_hash     (flow_hash),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .chosen_worker (chosen_worker),
        .status        (status),
        .list_count    (list_count),
        .ctl           (ctl),
        .stat          (stat)
    );

endmodule

`default_nettype wire
